// File: hw/rtl/tevd_pkg.sv
`default_nettype none

package tevd_pkg;

   localparam int unsigned QueueDepthDefault = 4;

   typedef enum logic [3:0] {
      PH_COUNT,
      PH_HDR,
      PH_ROSCNT,
      PH_LOCK,
      PH_ROSDATA,
      PH_GROUP,
      PH_PUCNT,
      PH_PUSKIP,
      PH_TRAIL
   } phase_type;

   localparam logic KIND_HIT = 1'b0;
   localparam logic KIND_END = 1'b1;

   localparam logic [3:0] TYPE_GROUP_HDR = 4'h0;
   localparam logic [3:0] TYPE_TRAILER   = 4'h1;
   localparam logic [3:0] TYPE_HIT       = 4'h4;
   localparam logic [3:0] TYPE_HIT_B     = 4'h6;
   localparam logic [3:0] TYPE_HIT_C     = 4'h7;
   localparam logic [3:0] TYPE_ROS_HDR   = 4'hF;

   localparam logic [31:0] WORD_EVENT_NUM  = 32'd3;
   localparam logic [31:0] WORD_ROS_OFFSET = 32'd6;
   localparam logic [31:0] WORD_PU_OFFSET  = 32'd7;
   localparam logic [31:0] WORD_HDR_LAST   = 32'd9;

   localparam int unsigned ERR_ROS_OFFSET = 0;
   localparam int unsigned ERR_ROS_COUNT  = 1;
   localparam int unsigned ERR_PU_OFFSET  = 2;
   localparam int unsigned ERR_TRAILER    = 3;

   typedef struct packed {
      logic is_ros_hdr;
      logic is_group_hdr;
      logic is_trailer;
      logic is_hit;
      logic is_group_data;
   } word_class_type;

   typedef struct packed {
      logic [31:0]    word;
      word_class_type cls;
   } entry_type;

   function automatic word_class_type classify(input logic [31:0] w);
      word_class_type c;
      logic [3:0]     t;
      t               = w[31:28];
      c.is_ros_hdr    = (t == TYPE_ROS_HDR);
      c.is_group_hdr  = (t == TYPE_GROUP_HDR);
      c.is_trailer    = (t == TYPE_TRAILER);
      c.is_hit        = (t == TYPE_HIT);
      c.is_group_data = (t == TYPE_HIT) || (t == TYPE_HIT_B) || (t == TYPE_HIT_C)
                        || (t == TYPE_ROS_HDR);
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tdc_event_word_deframer_unit.sv
`default_nettype none

// Event-frame deframer for TDC readout words. One 32-bit word enters per cycle
// while req_stall is low, and the unit sustains one word per cycle while no
// result is held: a small input queue takes the word and tags it, and the frame
// walker consumes one queued word each cycle, tracking the header, ROS, TDC
// group and PU sections with counter compares. Each type-4 word inside a TDC
// group gives a raw hit result; the trailing word count gives an event-end
// result with the offset and count mismatch mask. Results come from an output
// register that holds while rsp_stall is high; the queue (QueueDepth words)
// takes words until it fills. Board channel persists until the next ROS header.
module tdc_event_word_deframer_unit #(
   parameter int unsigned QueueDepth = tevd_pkg::QueueDepthDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_word,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_kind,
   output logic [31:0] rsp_event_number,
   output logic [11:0] rsp_group_event_id,
   output logic [2:0]  rsp_board_channel,
   output logic [3:0]  rsp_tdc_number,
   output logic [4:0]  rsp_channel_number,
   output logic [18:0] rsp_raw_time,
   output logic [3:0]  rsp_error_mask
);
   import tevd_pkg::*;

   logic      head_valid;
   entry_type head;
   logic      head_pop;

   tevd_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   tevd_walker u_walker (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head               (head),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_event_number   (rsp_event_number),
      .rsp_group_event_id (rsp_group_event_id),
      .rsp_board_channel  (rsp_board_channel),
      .rsp_tdc_number     (rsp_tdc_number),
      .rsp_channel_number (rsp_channel_number),
      .rsp_raw_time       (rsp_raw_time),
      .rsp_error_mask     (rsp_error_mask)
   );

endmodule

`default_nettype wire

// File: hw/rtl/tevd_front.sv
`default_nettype none

module tevd_front #(
   parameter int unsigned Depth = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [31:0]         req_word,
   output logic                head_valid,
   output tevd_pkg::entry_type head,
   input  wire                 head_pop
);
   import tevd_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   entry_type       slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;

   assign req_stall  = (count_ff == CntFull);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify on the way in so the walker decides on flags, not type bits
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{word: req_word, cls: classify(req_word)};
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow queue");

endmodule

`default_nettype wire

// File: hw/rtl/tevd_walker.sv
`default_nettype none

module tevd_walker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 head_valid,
   input  tevd_pkg::entry_type head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_kind,
   output logic [31:0]         rsp_event_number,
   output logic [11:0]         rsp_group_event_id,
   output logic [2:0]          rsp_board_channel,
   output logic [3:0]          rsp_tdc_number,
   output logic [4:0]          rsp_channel_number,
   output logic [18:0]         rsp_raw_time,
   output logic [3:0]          rsp_error_mask
);
   import tevd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] word_counter_ff, word_counter_in;
   logic [31:0] header_count_ff, header_count_in;
   logic [31:0] event_num_ff, event_num_in;
   logic [31:0] ros_offset_ff, ros_offset_in;
   logic [31:0] pu_offset_ff, pu_offset_in;
   logic [31:0] ros_end_ff, ros_end_in;
   logic [31:0] pu_rem_ff, pu_rem_in;
   logic [2:0]  rob_channel_ff, rob_channel_in;
   logic [11:0] group_id_ff, group_id_in;
   logic [3:0]  error_ff, error_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [31:0] out_event_ff, out_event_in;
   logic [11:0] out_gid_ff, out_gid_in;
   logic [2:0]  out_board_ff, out_board_in;
   logic [3:0]  out_tdc_ff, out_tdc_in;
   logic [4:0]  out_chan_ff, out_chan_in;
   logic [18:0] out_time_ff, out_time_in;
   logic [3:0]  out_err_ff, out_err_in;

   logic [31:0]    w;
   word_class_type cls;
   logic [31:0]    cnt_nx;
   logic           ros_done;
   logic           ros_closing;
   logic [31:0]    pu_start;
   logic [31:0]    pu_skip_nx;
   logic           emit;

   assign w          = head.word;
   assign cls        = head.cls;
   assign head_pop   = head_valid && (!out_valid_ff || !rsp_stall);
   assign cnt_nx     = word_counter_ff + 32'd1;
   assign ros_done   = (cnt_nx >= ros_end_ff);
   // ros section ends after a data word or a group word once the count is reached
   assign ros_closing = head_pop && ros_done &&
                        (((phase_ff == PH_ROSDATA) && !cls.is_group_hdr) ||
                         (phase_ff == PH_GROUP));
   assign pu_start   = (w != '0) ? w - 32'd1 : '0;
   assign pu_skip_nx = (pu_rem_ff != '0) ? pu_rem_ff - 32'd1 : '0;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (head_pop) begin
         case (phase_ff)
            PH_COUNT:   phase_in = PH_HDR;
            PH_HDR: begin
               if (cnt_nx >= WORD_HDR_LAST) phase_in = PH_ROSCNT;
            end
            PH_ROSCNT:  phase_in = PH_LOCK;
            PH_LOCK:    phase_in = PH_ROSDATA;
            PH_ROSDATA: begin
               if (cls.is_group_hdr) begin
                  phase_in = PH_GROUP;
               end else begin
                  phase_in = ros_done ? PH_PUCNT : PH_ROSDATA;
               end
            end
            PH_GROUP: begin
               if (cls.is_group_data) begin
                  if (ros_done) phase_in = PH_PUCNT;
               end else begin
                  phase_in = ros_done ? PH_PUCNT : PH_ROSDATA;
               end
            end
            PH_PUCNT:   phase_in = (pu_start == '0) ? PH_TRAIL : PH_PUSKIP;
            PH_PUSKIP: begin
               if (pu_skip_nx == '0) phase_in = PH_TRAIL;
            end
            PH_TRAIL:   phase_in = PH_COUNT;
            default:    phase_in = PH_COUNT;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      word_counter_in = word_counter_ff;
      header_count_in = header_count_ff;
      event_num_in    = event_num_ff;
      ros_offset_in   = ros_offset_ff;
      pu_offset_in    = pu_offset_ff;
      ros_end_in      = ros_end_ff;
      pu_rem_in       = pu_rem_ff;
      rob_channel_in  = rob_channel_ff;
      group_id_in     = group_id_ff;
      error_in        = error_ff;
      emit            = 1'b0;
      out_kind_in     = out_kind_ff;
      out_event_in    = out_event_ff;
      out_gid_in      = out_gid_ff;
      out_board_in    = out_board_ff;
      out_tdc_in      = out_tdc_ff;
      out_chan_in     = out_chan_ff;
      out_time_in     = out_time_ff;
      out_err_in      = out_err_ff;
      if (head_pop) begin
         word_counter_in = cnt_nx;
         case (phase_ff)
            PH_COUNT: begin
               word_counter_in = 32'd1;
               header_count_in = w;
               error_in        = '0;
            end
            PH_HDR: begin
               if (cnt_nx == WORD_EVENT_NUM)  event_num_in  = w;
               if (cnt_nx == WORD_ROS_OFFSET) ros_offset_in = w;
               if (cnt_nx == WORD_PU_OFFSET)  pu_offset_in  = w;
            end
            PH_ROSCNT: begin
               if (ros_offset_ff + 32'd1 != cnt_nx) error_in[ERR_ROS_OFFSET] = 1'b1;
               ros_end_in = w;
            end
            PH_LOCK: begin
               ros_end_in = cnt_nx + ros_end_ff - 32'd2;
            end
            PH_ROSDATA: begin
               if (cls.is_ros_hdr) begin
                  rob_channel_in = w[2:0];
               end else if (cls.is_group_hdr) begin
                  group_id_in = w[23:12];
               end
            end
            PH_GROUP: begin
               if (cls.is_hit) begin
                  emit         = 1'b1;
                  out_kind_in  = KIND_HIT;
                  out_event_in = event_num_ff;
                  out_gid_in   = group_id_ff;
                  out_board_in = rob_channel_ff;
                  out_tdc_in   = w[27:24];
                  out_chan_in  = w[23:19];
                  out_time_in  = w[18:0];
                  out_err_in   = '0;
               end else if (!cls.is_group_data && cls.is_trailer) begin
                  group_id_in = w[23:12];
               end
            end
            PH_PUCNT: begin
               if (pu_offset_ff + 32'd1 != cnt_nx) error_in[ERR_PU_OFFSET] = 1'b1;
               pu_rem_in = pu_start;
            end
            PH_PUSKIP: begin
               pu_rem_in = pu_skip_nx;
            end
            PH_TRAIL: begin
               if (w != header_count_ff) error_in[ERR_TRAILER] = 1'b1;
               emit         = 1'b1;
               out_kind_in  = KIND_END;
               out_event_in = event_num_ff;
               out_gid_in   = '0;
               out_board_in = '0;
               out_tdc_in   = '0;
               out_chan_in  = '0;
               out_time_in  = '0;
            end
            default: begin
            end
         endcase
         if (ros_closing && (ros_end_ff != cnt_nx)) error_in[ERR_ROS_COUNT] = 1'b1;
         if (phase_ff == PH_TRAIL) out_err_in = error_in;
      end
      out_valid_in = emit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_COUNT;
         word_counter_ff <= '0;
         header_count_ff <= '0;
         event_num_ff    <= '0;
         ros_offset_ff   <= '0;
         pu_offset_ff    <= '0;
         ros_end_ff      <= '0;
         pu_rem_ff       <= '0;
         rob_channel_ff  <= '0;
         group_id_ff     <= '1;
         error_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         word_counter_ff <= word_counter_in;
         header_count_ff <= header_count_in;
         event_num_ff    <= event_num_in;
         ros_offset_ff   <= ros_offset_in;
         pu_offset_ff    <= pu_offset_in;
         ros_end_ff      <= ros_end_in;
         pu_rem_ff       <= pu_rem_in;
         rob_channel_ff  <= rob_channel_in;
         group_id_ff     <= group_id_in;
         error_ff        <= error_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_event_ff <= out_event_in;
      out_gid_ff   <= out_gid_in;
      out_board_ff <= out_board_in;
      out_tdc_ff   <= out_tdc_in;
      out_chan_ff  <= out_chan_in;
      out_time_ff  <= out_time_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_event_number   = out_event_ff;
   assign rsp_group_event_id = out_gid_ff;
   assign rsp_board_channel  = out_board_ff;
   assign rsp_tdc_number     = out_tdc_ff;
   assign rsp_channel_number = out_chan_ff;
   assign rsp_raw_time       = out_time_ff;
   assign rsp_error_mask     = out_err_ff;

   a_hit_no_errors: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_HIT) |-> (out_err_ff == '0))
      else $error("hit word carries an error mask");

   a_no_pop_over_held: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !(out_valid_ff && rsp_stall))
      else $error("word taken while result held");

   a_event_start: assert property (@(posedge clock) disable iff (reset)
      (head_pop && phase_ff == PH_COUNT) |=>
         (word_counter_ff == 32'd1 && phase_ff == PH_HDR && error_ff == '0))
      else $error("event start did not restart counters");

endmodule

`default_nettype wire
